// ----- rtl/kcv3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcv3_pkg
// Shared types and constants of the 3D constant-velocity tracker.
// ----------------------------------------------------------------------------
package kcv3_pkg;

  localparam int VALUE_W      = 32;
  localparam int NOISE_W      = 24;
  localparam int TIME_W       = 20;
  localparam int AXES         = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  localparam logic REG_PNOISE = 1'b0;
  localparam logic REG_MNOISE = 1'b1;

  localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'(65536);

  typedef struct packed {
    logic                      req_type;
    logic [TIME_W-1:0]         elapsed_time;
    logic signed [VALUE_W-1:0] meas_x;
    logic signed [VALUE_W-1:0] meas_y;
    logic signed [VALUE_W-1:0] meas_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] filt_x;
    logic signed [VALUE_W-1:0] filt_y;
    logic signed [VALUE_W-1:0] filt_z;
  } out_item_t;

  // Command broadcast to every axis lane.
  typedef struct packed {
    logic                      start;
    logic                      req_type;
    logic signed [VALUE_W-1:0] dt;
    logic signed [VALUE_W-1:0] pn;
    logic signed [VALUE_W-1:0] mn;
  } lane_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_Q, ST_R, ST_T2, ST_T3, ST_T4, ST_PP, ST_PV1, ST_PV2,
    ST_PP1, ST_PP2, ST_PP3, ST_VV, ST_DIV, ST_KP, ST_KV, ST_POS, ST_VEL,
    ST_VPP, ST_VVV, ST_CPV
  } lane_state_e;

endpackage
`default_nettype wire

// ----- rtl/kcv3_recip.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcv3_recip
// Restoring divider: 2^(2*FRAC_BITS) / divisor, one quotient bit a cycle,
// truncated toward zero and saturated to the value range.
// ----------------------------------------------------------------------------
module kcv3_recip #(
  parameter int FRAC_BITS = kcv3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [kcv3_pkg::VALUE_W:0]   divisor_i,
  output logic                                     done_o,
  output logic signed [kcv3_pkg::VALUE_W-1:0]      quot_o
);
  import kcv3_pkg::*;

  localparam int W  = VALUE_W;
  localparam int N  = W + 1;
  localparam int QB = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QB);
  localparam int LW = QB + W + 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N-1:0]  rem_q, rem_d;
  logic [N-1:0]  dvs_q, dvs_d;
  logic [QB-1:0] quo_q, quo_d;
  logic          neg_q, neg_d;
  logic [N:0]    trial;
  logic [LW-1:0] quo_ext, lim;
  logic [W-1:0]  mag;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    // the dividend has a single set bit, shifted in on the first step
    trial  = {rem_q, (cnt_q == CW'(QB - 1))};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QB - 1);
      rem_d  = '0;
      quo_d  = '0;
      neg_d  = divisor_i[N-1];
      dvs_d  = divisor_i[N-1] ? N'(-divisor_i) : N'(divisor_i);
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = N'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[QB-2:0], 1'b1};
      end else begin
        rem_d = trial[N-1:0];
        quo_d = {quo_q[QB-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  always_comb begin
    quo_ext = LW'(quo_q);
    lim     = (LW'(1) << (W - 1)) - (neg_q ? LW'(0) : LW'(1));
    mag     = quo_ext[W-1:0];
    if (quo_ext > lim) begin
      quot_o = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      quot_o = neg_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- rtl/kcv3_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcv3_lane
// One axis filter: a sequencer around one fixed-point multiplier and a
// reciprocal unit, holding position, velocity and 2x2 covariance.
// ----------------------------------------------------------------------------
module kcv3_lane #(
  parameter int FRAC_BITS = kcv3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire kcv3_pkg::lane_cmd_t                cmd_i,
  input  wire logic signed [kcv3_pkg::VALUE_W-1:0] meas_i,
  output logic                                    busy_o,
  output logic signed [kcv3_pkg::VALUE_W-1:0]     pos_o
);
  import kcv3_pkg::*;

  localparam int W  = VALUE_W;
  localparam int N  = W + 1;
  localparam int SW = W + 3;
  localparam logic signed [SW-1:0] VMAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN_S = -VMAX_S - 1;

  typedef logic signed [W-1:0]  val_t;
  typedef logic signed [N-1:0]  op_t;
  typedef logic signed [SW-1:0] sum_t;

  lane_state_e state_q, state_d;

  val_t pos_q, vel_q, vpp_q, cpv_q, vvv_q;
  val_t dt_q, pn_q, mn_q, m_q, q_q, r_q, t2_q, t3_q, t4_q;
  val_t pp_q, ppv_q, ppp_q, pvv_q, inv_q, kp_q, kv_q;
  sum_t acc_q;
  op_t  e_q;

  op_t  ma, mb;
  val_t mr;
  op_t  div_s;
  logic div_start, div_done;
  val_t div_quot;

  function automatic op_t ext_n(input val_t x);
    return {x[W-1], x};
  endfunction

  function automatic sum_t ext_s(input val_t x);
    return {{(SW-W){x[W-1]}}, x};
  endfunction

  function automatic val_t sat(input sum_t x);
    if (x > VMAX_S) return VMAX_S[W-1:0];
    if (x < VMIN_S) return VMIN_S[W-1:0];
    return x[W-1:0];
  endfunction

  // exact product, round half away from zero, saturate
  function automatic val_t fmul(input op_t a, input op_t b);
    logic signed [2*N-1:0] prod;
    logic [2*N-1:0]        mag, rnd, lim;
    logic                  neg;
    val_t                  res;
    prod = a * b;
    neg  = prod[2*N-1];
    mag  = neg ? (~prod + 1'b1) : prod;
    rnd  = (mag + ((2*N)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = ((2*N)'(1) << (W - 1)) - (neg ? (2*N)'(0) : (2*N)'(1));
    res  = rnd[W-1:0];
    if (rnd > lim) return neg ? VMIN_S[W-1:0] : VMAX_S[W-1:0];
    return neg ? -res : res;
  endfunction

  // divide by two and four, truncating toward zero
  function automatic sum_t half(input val_t x);
    return (ext_s(x) + (x[W-1] ? sum_t'(1) : sum_t'(0))) >>> 1;
  endfunction

  function automatic sum_t quarter(input val_t x);
    return (ext_s(x) + (x[W-1] ? sum_t'(3) : sum_t'(0))) >>> 2;
  endfunction

  assign div_s = N'(ext_n(ppp_q) + ext_n(r_q));

  kcv3_recip #(
    .FRAC_BITS(FRAC_BITS)
  ) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .divisor_i(div_s),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    ma        = '0;
    mb        = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.start && (cmd_i.req_type == REQ_UPDATE)) state_d = ST_Q;
      end
      ST_Q:   begin ma = ext_n(pn_q); mb = ext_n(pn_q);  state_d = ST_R;   end
      ST_R:   begin ma = ext_n(mn_q); mb = ext_n(mn_q);  state_d = ST_T2;  end
      ST_T2:  begin ma = ext_n(dt_q); mb = ext_n(dt_q);  state_d = ST_T3;  end
      ST_T3:  begin ma = ext_n(t2_q); mb = ext_n(dt_q);  state_d = ST_T4;  end
      ST_T4:  begin ma = ext_n(t2_q); mb = ext_n(t2_q);  state_d = ST_PP;  end
      ST_PP:  begin ma = ext_n(dt_q); mb = ext_n(vel_q); state_d = ST_PV1; end
      ST_PV1: begin ma = ext_n(dt_q); mb = ext_n(vvv_q); state_d = ST_PV2; end
      ST_PV2: begin ma = ext_n(q_q);  mb = ext_n(t3_q);  state_d = ST_PP1; end
      ST_PP1: begin ma = ext_n(dt_q); mb = ext_n(cpv_q); state_d = ST_PP2; end
      ST_PP2: begin ma = ext_n(t2_q); mb = ext_n(vvv_q); state_d = ST_PP3; end
      ST_PP3: begin ma = ext_n(q_q);  mb = ext_n(t4_q);  state_d = ST_VV;  end
      ST_VV: begin
        ma = ext_n(q_q);
        mb = ext_n(t2_q);
        // skip the divider on a zero innovation variance
        if (div_s == '0) begin
          state_d = ST_KP;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_KP;
      end
      ST_KP:  begin ma = ext_n(ppp_q); mb = ext_n(inv_q); state_d = ST_KV;  end
      ST_KV:  begin ma = ext_n(ppv_q); mb = ext_n(inv_q); state_d = ST_POS; end
      ST_POS: begin ma = ext_n(kp_q);  mb = e_q;          state_d = ST_VEL; end
      ST_VEL: begin ma = ext_n(kv_q);  mb = e_q;          state_d = ST_VPP; end
      ST_VPP: begin ma = ext_n(kp_q);  mb = ext_n(ppp_q); state_d = ST_VVV; end
      ST_VVV: begin ma = ext_n(kv_q);  mb = ext_n(ppv_q); state_d = ST_CPV; end
      ST_CPV: begin ma = ext_n(kp_q);  mb = ext_n(ppv_q); state_d = ST_IDLE; end
      default: state_d = ST_IDLE;
    endcase
  end

  assign mr = fmul(ma, mb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
      vpp_q <= '0;
      cpv_q <= '0;
      vvv_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_i.start && (cmd_i.req_type == REQ_START)) begin
            pos_q <= meas_i;
            vel_q <= '0;
            vpp_q <= '0;
            cpv_q <= '0;
            vvv_q <= '0;
          end
        end
        ST_POS: pos_q <= sat(ext_s(pp_q) + ext_s(mr));
        ST_VEL: vel_q <= sat(ext_s(vel_q) + ext_s(mr));
        ST_VPP: vpp_q <= sat(ext_s(ppp_q) - ext_s(mr));
        ST_VVV: vvv_q <= sat(ext_s(pvv_q) - ext_s(mr));
        ST_CPV: cpv_q <= sat(ext_s(ppv_q) - ext_s(mr));
        default: ;
      endcase
    end
  end

  // working values
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          dt_q <= cmd_i.dt;
          pn_q <= cmd_i.pn;
          mn_q <= cmd_i.mn;
          m_q  <= meas_i;
        end
      end
      ST_Q:   q_q   <= mr;
      ST_R:   r_q   <= mr;
      ST_T2:  t2_q  <= mr;
      ST_T3:  t3_q  <= mr;
      ST_T4:  t4_q  <= mr;
      ST_PP:  pp_q  <= sat(ext_s(pos_q) + ext_s(mr));
      ST_PV1: acc_q <= ext_s(cpv_q) + ext_s(mr);
      ST_PV2: ppv_q <= sat(acc_q + half(mr));
      ST_PP1: acc_q <= ext_s(vpp_q) + (ext_s(mr) <<< 1);
      ST_PP2: acc_q <= acc_q + ext_s(mr);
      ST_PP3: ppp_q <= sat(acc_q + quarter(mr));
      ST_VV: begin
        pvv_q <= sat(ext_s(vvv_q) + ext_s(mr));
        inv_q <= '0;
      end
      ST_DIV: begin
        if (div_done) inv_q <= div_quot;
      end
      ST_KP:  kp_q <= mr;
      ST_KV: begin
        kv_q <= mr;
        e_q  <= ext_n(m_q) - ext_n(pp_q);
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign pos_o  = pos_q;

endmodule
`default_nettype wire

// ----- rtl/kalman_constant_velocity_3d_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_constant_velocity_3d_core
// Constant-velocity Kalman tracker for one 3D point, three axis lanes.
// ----------------------------------------------------------------------------
// Input words carry a request type, the elapsed time and a measured 3D
// location; each accepted word yields one output word with the filtered
// position of all three axes. A start request loads the position and clears
// velocity and covariance. An update request runs in all three lanes at
// once: 12 multiplier steps, the bit-serial reciprocal unit (2*FRAC_BITS+1
// quotient bits, skipped on a zero divisor), then 7 more multiplier steps.
// One word is in work at a time: in_stall_o is high from accept until the
// result moves into the output register, so the next word can be taken in
// the same cycle that output valid rises. The output register holds a
// finished word while out_stall_i is high; the next input word may be
// accepted meanwhile, and its result waits until the register is free.
// Reset clears the track state and sets both noise registers to 1.0. The
// user must write the noise registers over the APB-style port only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module kalman_constant_velocity_3d_core #(
  parameter int FRAC_BITS = kcv3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire kcv3_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output kcv3_pkg::out_item_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kcv3_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [kcv3_pkg::DATA_W-1:0]   pwdata,
  output logic [kcv3_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import kcv3_pkg::*;

  localparam int W  = VALUE_W;
  localparam int XW = 2 * NOISE_W;

  logic [NOISE_W-1:0] pnoise_q, mnoise_q;
  logic               running_q, running_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q;
  logic               in_acc, finish, any_busy;
  lane_cmd_t          cmd;
  logic signed [W-1:0] meas [AXES];
  logic signed [W-1:0] pos  [AXES];
  logic [AXES-1:0]     busy;

  function automatic logic signed [W-1:0] from_q16(input logic [NOISE_W-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    if (FRAC_BITS >= 16) x = x << (FRAC_BITS - 16);
    else x = x >> (16 - FRAC_BITS);
    if (x > XW'({1'b0, {(W-1){1'b1}}})) return {1'b0, {(W-1){1'b1}}};
    return x[W-1:0];
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnoise_q <= NOISE_RESET;
      mnoise_q <= NOISE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_PNOISE: pnoise_q <= pwdata[NOISE_W-1:0];
        REG_MNOISE: mnoise_q <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PNOISE: prdata = DATA_W'(pnoise_q);
      REG_MNOISE: prdata = DATA_W'(mnoise_q);
      default:    prdata = '0;
    endcase
  end

  // lanes
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    cmd.start    = in_acc;
    cmd.req_type = in_data_i.req_type;
    cmd.dt       = from_q16(NOISE_W'(in_data_i.elapsed_time));
    cmd.pn       = from_q16(pnoise_q);
    cmd.mn       = from_q16(mnoise_q);
    meas[0]      = in_data_i.meas_x;
    meas[1]      = in_data_i.meas_y;
    meas[2]      = in_data_i.meas_z;
  end

  for (genvar k = 0; k < AXES; k++) begin : g_lane
    kcv3_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .meas_i(meas[k]),
      .busy_o(busy[k]),
      .pos_o (pos[k])
    );
  end

  // merge lane results into the output register
  assign any_busy = |busy;
  assign finish   = running_q && !any_busy && (!out_valid_q || !out_stall_i);

  always_comb begin
    running_d   = running_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc) running_d = 1'b1;
    if (finish) begin
      running_d   = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q.filt_x <= pos[0];
      out_q.filt_y <= pos[1];
      out_q.filt_z <= pos[2];
    end
  end

  assign in_stall_o  = running_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- rtl/kcv3_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kcv3_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module kcv3_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire kcv3_pkg::out_item_t out_data_o
);
  import kcv3_pkg::*;

  // an accepted word keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new output word only comes from a word in work
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a word in work");

  // nothing in work: a taken output word is not replaced
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_stall_o |=> !out_valid_o)
    else $error("output word appeared with nothing in work");

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

endmodule

bind kalman_constant_velocity_3d_core kcv3_checker u_kcv3_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3D constant-velocity tracker. A driver feeds
// words from a pending queue. A fixed-point predictor computes the filtered
// position of every accepted word. A monitor compares each output word with
// the oldest prediction. Phases change the noise registers over the APB port.
// ----------------------------------------------------------------------------
module tb;
  import kcv3_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  kalman_constant_velocity_3d_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  pending_words[$];
  out_item_t filt_expected[$];
  int  fail_cnt = 0;
  bit  sender_hold = 1'b0;
  bit  no_idle = 1'b0;
  bit  rx_hold_armed = 1'b0;

  // predictor state
  longint trk_pos[3], trk_vel[3], trk_ppp[3], trk_ppv[3], trk_pvv[3];
  logic [NOISE_W-1:0] cfg_pnoise = NOISE_RESET;
  logic [NOISE_W-1:0] cfg_mnoise = NOISE_RESET;

  function automatic longint sat_v(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  // rounded fixed-point product, saturated
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] pr;
    logic [127:0] mag;
    logic [127:0] res;
    bit neg;
    longint lim;
    neg = (a < 0) != (b < 0);
    pr = a;
    pr = pr * b;
    mag = (pr < 0) ? -pr : pr;
    res = (mag + 128'd32768) >> 16;
    lim = neg ? VMAX + 1 : VMAX;
    if (res > lim) return neg ? VMIN : VMAX;
    return neg ? -longint'(res) : longint'(res);
  endfunction

  task automatic filter_word(input in_item_t w);
    longint m[3];
    longint dt, q, r, t2, t3, t4, p, v, pvv, ppv, ppp, s, inv, kp, kv, e;
    out_item_t o;
    m[0] = w.meas_x;
    m[1] = w.meas_y;
    m[2] = w.meas_z;
    if (w.req_type == REQ_START) begin
      for (int k = 0; k < 3; k++) begin
        trk_pos[k] = m[k];
        trk_vel[k] = 0; trk_ppp[k] = 0; trk_ppv[k] = 0; trk_pvv[k] = 0;
      end
    end else begin
      dt = {44'b0, w.elapsed_time};
      q = fx_mul({40'b0, cfg_pnoise}, {40'b0, cfg_pnoise});
      r = fx_mul({40'b0, cfg_mnoise}, {40'b0, cfg_mnoise});
      t2 = fx_mul(dt, dt);
      t3 = fx_mul(t2, dt);
      t4 = fx_mul(t2, t2);
      for (int k = 0; k < 3; k++) begin
        p = sat_v(trk_pos[k] + fx_mul(dt, trk_vel[k]));
        v = trk_vel[k];
        pvv = trk_pvv[k];
        ppv = sat_v(trk_ppv[k] + fx_mul(dt, pvv) + fx_mul(q, t3) / 2);
        ppp = sat_v(trk_ppp[k] + 2 * fx_mul(dt, trk_ppv[k]) + fx_mul(t2, pvv)
                    + fx_mul(q, t4) / 4);
        pvv = sat_v(pvv + fx_mul(q, t2));
        s = ppp + r;
        // zero divisor: both gains vanish
        inv = (s == 0) ? 0 : sat_v((64'sd1 << 32) / s);
        kp = fx_mul(ppp, inv);
        kv = fx_mul(ppv, inv);
        e = m[k] - p;
        trk_pos[k] = sat_v(p + fx_mul(kp, e));
        trk_vel[k] = sat_v(v + fx_mul(kv, e));
        trk_ppp[k] = sat_v(ppp - fx_mul(kp, ppp));
        trk_pvv[k] = sat_v(pvv - fx_mul(kv, ppv));
        trk_ppv[k] = sat_v(ppv - fx_mul(kp, ppv));
      end
    end
    o.filt_x = trk_pos[0][31:0];
    o.filt_y = trk_pos[1][31:0];
    o.filt_z = trk_pos[2][31:0];
    filt_expected.push_back(o);
  endtask

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 37);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        filter_word(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (pending_words.size() > 0 && !sender_hold && !idle_now()) begin
        in_valid <= 1'b1;
        in_data <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  int rx_hold_left = 0;
  bit rx_hold_used = 1'b0;
  always @(posedge clk) begin
    out_item_t x;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (filt_expected.size() == 0) begin
          $error("unexpected output word %h", out_data);
          fail_cnt++;
        end else begin
          x = filt_expected.pop_front();
          if (out_data.filt_x !== x.filt_x) begin
            $error("filt_x expected %h actual %h", x.filt_x, out_data.filt_x);
            fail_cnt++;
          end
          if (out_data.filt_y !== x.filt_y) begin
            $error("filt_y expected %h actual %h", x.filt_y, out_data.filt_y);
            fail_cnt++;
          end
          if (out_data.filt_z !== x.filt_z) begin
            $error("filt_z expected %h actual %h", x.filt_z, out_data.filt_z);
            fail_cnt++;
          end
        end
      end
      if (rx_hold_armed && !rx_hold_used) begin
        rx_hold_used <= 1'b1;
        rx_hold_left <= 3000;
        out_stall <= 1'b1;
      end else if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  // watchdog on cycles without any accepted input word or taken output word
  int wdog_cnt = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wdog_cnt <= 0;
    end else if (wdog_cnt >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_noise(input logic [DATA_W-1:0] pn, input logic [DATA_W-1:0] mn);
    apb_write(ADDR_W'(4 * REG_PNOISE), pn);
    cfg_pnoise = pn[NOISE_W-1:0];
    apb_write(ADDR_W'(4 * REG_MNOISE), mn);
    cfg_mnoise = mn[NOISE_W-1:0];
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || filt_expected.size() > 0)
      @(negedge clk);
  endtask

  function automatic in_item_t mk_word(logic rt, logic [TIME_W-1:0] t,
                                       logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t w;
    w.req_type = rt; w.elapsed_time = t;
    w.meas_x = x; w.meas_y = y; w.meas_z = z;
    return w;
  endfunction

  // mostly coherent tracks with small steps, some raw noise
  task automatic push_random(input int n);
    int base[3];
    in_item_t w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        w = mk_word(1'($urandom_range(0, 1)), TIME_W'($urandom), $urandom, $urandom,
                    $urandom);
      end else if (i == 0 || $urandom_range(0, 14) == 0) begin
        for (int k = 0; k < 3; k++) base[k] = $signed($urandom) >>> $urandom_range(0, 12);
        w = mk_word(REQ_START, TIME_W'($urandom), base[0], base[1], base[2]);
      end else begin
        for (int k = 0; k < 3; k++)
          base[k] = base[k] + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        w = mk_word(REQ_UPDATE, TIME_W'($urandom_range(0, 1 << 17)), base[0], base[1],
                    base[2]);
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    for (int k = 0; k < 3; k++) begin
      trk_pos[k] = 0; trk_vel[k] = 0; trk_ppp[k] = 0; trk_ppv[k] = 0; trk_pvv[k] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: update before start, field extremes
    no_idle = 1'b1;
    pending_words.push_back(mk_word(REQ_UPDATE, 20'hFFFFF, 32'h7FFFFFFF, 32'h80000000, 0));
    pending_words.push_back(mk_word(REQ_START, '0, 32'h7FFFFFFF, 32'h80000000, 0));
    pending_words.push_back(mk_word(REQ_UPDATE, '0, 32'h80000000, 32'h7FFFFFFF, 1));
    pending_words.push_back(mk_word(REQ_UPDATE, 20'hFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                    32'hFFFFFFFF));
    pending_words.push_back(mk_word(REQ_START, 20'hFFFFF, 0, 0, 0));
    pending_words.push_back(mk_word(REQ_UPDATE, 20'h10000, 32'h00010000, 32'hFFFF0000,
                                    32'h00008000));
    pending_words.push_back(mk_word(REQ_UPDATE, 20'h00001, 32'h00020000, 32'hFFFE0000,
                                    32'h00010000));
    wait_drained();
    no_idle = 1'b0;
    push_random(100);
    wait_drained();
    repeat (80) @(negedge clk);

    // zero noise: zero divisor after a start
    set_noise(0, 0);
    pending_words.push_back(mk_word(REQ_START, '0, 32'h00050000, 32'hFFFB0000, 0));
    pending_words.push_back(mk_word(REQ_UPDATE, '0, 32'h7FFFFFFF, 32'h80000000, 5));
    pending_words.push_back(mk_word(REQ_UPDATE, 20'h08000, 32'h00060000, 32'hFFFA0000, 3));
    push_random(110);
    rx_hold_armed = 1'b1;
    wait_drained();
    repeat (80) @(negedge clk);

    // top noise, stray upper bits in the write data
    set_noise(32'hFFFFFFFF, 32'hA5FFFFFF);
    push_random(60);
    while (pending_words.size() > 30) @(negedge clk);
    sender_hold = 1'b1;
    while (filt_expected.size() > 0 || in_valid) @(negedge clk);
    sender_hold = 1'b0;
    push_random(60);
    wait_drained();
    repeat (80) @(negedge clk);

    set_noise(0, 32'h00FFFFFF);
    push_random(100);
    wait_drained();
    repeat (80) @(negedge clk);

    set_noise($urandom, $urandom);
    no_idle = 1'b1;
    push_random(60);
    wait_drained();
    no_idle = 1'b0;
    push_random(60);
    wait_drained();
    repeat (80) @(negedge clk);

    set_noise($urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000));
    push_random(120);
    wait_drained();

    repeat (100) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
